### rtl/sensor_spi_register_master_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor SPI register master
// Shared concurrent assertion forms, clocked on aclk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_SPI_REGISTER_MASTER_TOP_ASSERT_SVH
`define SENSOR_SPI_REGISTER_MASTER_TOP_ASSERT_SVH

// same-cycle implication
`define SSRM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSRM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssrm_pkg.sv
// ----------------------------------------------------------------------------
// ssrm_pkg
// Shared constants, request codes and record types of the SPI register master.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrm_pkg;

    localparam int MAX_BURST_DEF = 256;
    localparam int QUEUE_DEPTH   = 2;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    // classified request, as held in the queue
    typedef struct packed {
        logic       is_start;
        logic       is_data;
        logic       is_tick;
        logic       is_read;
        logic [7:0] reg_address;
        logic [8:0] transfer_length;
        logic [7:0] write_byte;
        logic       miso_level;
    } cmd_t;

    typedef struct packed {
        logic       rejected;
        logic       done_res;
        logic       need_data;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       clock_pulse;
        logic       mosi_level;
        logic       select_level;
    } res_t;

endpackage

`default_nettype wire

### rtl/sensor_spi_register_master_top.sv
// ----------------------------------------------------------------------------
// sensor_spi_register_master_top
// SPI master for sensor register bursts, streaming request/result interface.
// ----------------------------------------------------------------------------
// Every request (start, write data byte, serial clock tick or no-op) yields
// exactly one result. Requests are taken one per clock while the queue has
// room, and results leave one per clock while the master side takes them. A
// request goes through the queue, then the result register. A two-entry queue
// sits between the request decoder and the burst sequencer, and a result
// register sits at the output, so a stalled result side holds up the slave
// side only once the queue is full. The sequencer handles one request per
// cycle while the result register can take one; that sets the sustained rate.
`default_nettype none

module sensor_spi_register_master_top #(
    parameter int MAX_BURST = ssrm_pkg::MAX_BURST_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] is_read, [8:1] reg_address, [17:9] transfer_length,
    // [25:18] write_byte, [26] miso_level, [31:27] zero
    input  wire logic [ssrm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] kind
    input  wire logic [ssrm_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [0] select_level, [1] mosi_level, [2] clock_pulse, [3] read_valid,
    // [11:4] read_byte, [12] need_data, [13] done_res, [14] rejected, [15] zero
    output logic [ssrm_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    logic           q_valid;
    logic           q_pop;
    ssrm_pkg::cmd_t q_cmd;

    ssrm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_cmd         (q_cmd)
    );

    ssrm_back #(
        .MAX_BURST (MAX_BURST)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_cmd         (q_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### rtl/ssrm_front.sv
// ----------------------------------------------------------------------------
// ssrm_front
// Accepts requests, decodes the kind and queues them for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrm_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [ssrm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [ssrm_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               q_valid,
    input  wire logic                          q_pop,
    output ssrm_pkg::cmd_t                     q_cmd
);

    localparam int PTR_W = (ssrm_pkg::QUEUE_DEPTH > 1) ? $clog2(ssrm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ssrm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ssrm_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ssrm_pkg::QUEUE_DEPTH);

    ssrm_pkg::cmd_t   entry_reg [ssrm_pkg::QUEUE_DEPTH];
    ssrm_pkg::cmd_t   dec;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    // decode; no-op requests carry no flag
    always_comb begin
        dec                 = '0;
        dec.is_start        = (s_axis_tuser == ssrm_pkg::KIND_START);
        dec.is_data         = (s_axis_tuser == ssrm_pkg::KIND_DATA);
        dec.is_tick         = (s_axis_tuser == ssrm_pkg::KIND_TICK);
        dec.is_read         = s_axis_tdata[0];
        dec.reg_address     = s_axis_tdata[8:1];
        dec.transfer_length = s_axis_tdata[17:9];
        dec.write_byte      = s_axis_tdata[25:18];
        dec.miso_level      = s_axis_tdata[26];
    end

    assign s_axis_tready = (count_reg != CNT_FULL);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign q_cmd         = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (q_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

### rtl/ssrm_back.sv
// ----------------------------------------------------------------------------
// ssrm_back
// Burst sequencer: a queued request per cycle to the result register, if free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_spi_register_master_top_assert.svh"

module ssrm_back #(
    parameter int MAX_BURST = ssrm_pkg::MAX_BURST_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    output logic                                q_pop,
    input  wire ssrm_pkg::cmd_t                 q_cmd,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [ssrm_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int BL_W = $clog2(MAX_BURST + 1);

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_RW    = 6'b000010,
        PH_ADDR  = 6'b000100,
        PH_WDATA = 6'b001000,
        PH_DUMMY = 6'b010000,
        PH_RDATA = 6'b100000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [2:0]      bit_count_reg, bit_count_next;
    logic [7:0]      shift_reg, shift_next;
    logic [BL_W-1:0] bytes_left_reg, bytes_left_next;
    logic            read_mode_reg, read_mode_next;
    logic [7:0]      address_hold_reg, address_hold_next;
    logic [7:0]      data_hold_reg, data_hold_next;
    logic            hold_full_reg, hold_full_next;
    logic            out_valid_reg, out_valid_next;
    ssrm_pkg::res_t  res_reg, res_next;

    logic [31:0]     len_sat;
    logic [BL_W-1:0] bytes_dec;
    logic [7:0]      sh;

    assign q_pop = q_valid && (!out_valid_reg || m_axis_tready);

    assign len_sat = ({23'd0, q_cmd.transfer_length} > 32'(MAX_BURST)) ?
                     32'(MAX_BURST) : {23'd0, q_cmd.transfer_length};
    assign bytes_dec = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : '0;

    always_comb begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_next        = shift_reg;
        bytes_left_next   = bytes_left_reg;
        read_mode_next    = read_mode_reg;
        address_hold_next = address_hold_reg;
        data_hold_next    = data_hold_reg;
        hold_full_next    = hold_full_reg;
        res_next          = '0;
        sh                = shift_reg;

        if (q_pop) begin
            priority if (q_cmd.is_start) begin
                if (phase_reg != PH_IDLE) begin
                    res_next.rejected = 1'b1;
                end else begin
                    read_mode_next    = q_cmd.is_read;
                    address_hold_next = q_cmd.reg_address;
                    bytes_left_next   = BL_W'(len_sat);
                    bit_count_next    = '0;
                    shift_next        = '0;
                    phase_next        = PH_RW;
                end
            end else if (q_cmd.is_data) begin
                if (hold_full_reg) begin
                    res_next.rejected = 1'b1;
                end else begin
                    data_hold_next = q_cmd.write_byte;
                    hold_full_next = 1'b1;
                end
            end else if (q_cmd.is_tick) begin
                unique case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_RW: begin
                        res_next.mosi_level  = !read_mode_reg;
                        res_next.clock_pulse = 1'b1;
                        shift_next           = address_hold_reg;
                        bit_count_next       = '0;
                        phase_next           = PH_ADDR;
                    end
                    PH_ADDR: begin
                        res_next.mosi_level  = shift_reg[7];
                        res_next.clock_pulse = 1'b1;
                        shift_next           = {shift_reg[6:0], 1'b0};
                        bit_count_next       = bit_count_reg + 1'b1;
                        if (bit_count_reg == 3'd7) begin
                            if (read_mode_reg) begin
                                phase_next = PH_DUMMY;
                            end else if (bytes_left_reg == '0) begin
                                phase_next        = PH_IDLE;
                                res_next.done_res = 1'b1;
                            end else begin
                                phase_next = PH_WDATA;
                            end
                        end
                    end
                    PH_WDATA: begin
                        // byte boundary with nothing held: stall, no pulse
                        if (bit_count_reg != '0 || hold_full_reg) begin
                            if (bit_count_reg == '0) begin
                                sh             = data_hold_reg;
                                hold_full_next = 1'b0;
                            end
                            res_next.mosi_level  = sh[7];
                            res_next.clock_pulse = 1'b1;
                            shift_next           = {sh[6:0], 1'b0};
                            bit_count_next       = bit_count_reg + 1'b1;
                            if (bit_count_reg == 3'd7) begin
                                bytes_left_next = bytes_dec;
                                if (bytes_dec == '0) begin
                                    phase_next        = PH_IDLE;
                                    res_next.done_res = 1'b1;
                                end
                            end
                        end
                    end
                    PH_DUMMY: begin
                        res_next.clock_pulse = 1'b1;
                        bit_count_next       = '0;
                        shift_next           = '0;
                        if (bytes_left_reg == '0) begin
                            phase_next        = PH_IDLE;
                            res_next.done_res = 1'b1;
                        end else begin
                            phase_next = PH_RDATA;
                        end
                    end
                    PH_RDATA: begin
                        sh                   = {shift_reg[6:0], q_cmd.miso_level};
                        res_next.clock_pulse = 1'b1;
                        bit_count_next       = bit_count_reg + 1'b1;
                        shift_next           = sh;
                        if (bit_count_reg == 3'd7) begin
                            res_next.read_valid = 1'b1;
                            res_next.read_byte  = sh;
                            shift_next          = '0;
                            bytes_left_next     = bytes_dec;
                            if (bytes_dec == '0) begin
                                phase_next        = PH_IDLE;
                                res_next.done_res = 1'b1;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end else begin
            end

            if (phase_next == PH_IDLE) begin
                bit_count_next = '0;
            end
            res_next.select_level = (phase_next != PH_IDLE);
            res_next.need_data    = (phase_next == PH_WDATA) && (bit_count_next == '0) &&
                                    !hold_full_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            bytes_left_reg <= '0;
            read_mode_reg  <= 1'b0;
            hold_full_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            bytes_left_reg <= bytes_left_next;
            read_mode_reg  <= read_mode_next;
            hold_full_reg  <= hold_full_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, loaded before use
    always_ff @(posedge aclk) begin
        shift_reg        <= shift_next;
        address_hold_reg <= address_hold_next;
        data_hold_reg    <= data_hold_next;
        if (q_pop) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg};

    `SSRM_ASSERT_IMP(a_idle_count_clear, phase_reg == PH_IDLE, bit_count_reg == '0,
        "bit counter not cleared while idle")
    `SSRM_ASSERT_IMP(a_done_deselects, out_valid_reg && res_reg.done_res,
        !res_reg.select_level, "done reported with select still high")
    `SSRM_ASSERT_IMP(a_read_has_pulse, out_valid_reg && res_reg.read_valid,
        res_reg.clock_pulse, "read byte without a clock pulse")
    `SSRM_ASSERT_IMP(a_hold_drain, $fell(hold_full_reg) && $past(aresetn),
        $past(q_pop && q_cmd.is_tick && phase_reg == PH_WDATA),
        "holding register emptied outside a write data tick")
    `SSRM_ASSERT_NXT(a_start_opens, q_pop && q_cmd.is_start && phase_reg == PH_IDLE,
        phase_reg == PH_RW, "accepted start did not open a burst")

endmodule

`default_nettype wire

### tb/sv/sensor_spi_register_master_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_spi_register_master_top_tb
// Self-checking bench for the SPI register burst master. Every request is
// predicted as it is accepted, and each result is checked field by field
// against the oldest prediction. Directed edge cases are run first, then a
// saturated read, a back-pressure pass and randomised bursts with noise.
// ----------------------------------------------------------------------------

module sensor_spi_register_master_top_tb;

    localparam int BURST_CAP       = ssrm_pkg::MAX_BURST_DEF;
    localparam int RANDOM_REQUESTS = 250;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int TAIL_CYCLES     = 8;

    typedef enum logic [5:0] {
        SEQ_IDLE  = 6'b000001,
        SEQ_DIR   = 6'b000010,
        SEQ_ADDR  = 6'b000100,
        SEQ_WDATA = 6'b001000,
        SEQ_DUMMY = 6'b010000,
        SEQ_RDATA = 6'b100000
    } seq_phase_t;

    logic                           aclk          = 1'b0;
    logic                           aresetn       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [0] is_read, [8:1] reg_address, [17:9] transfer_length,
    // [25:18] write_byte, [26] miso_level, [31:27] zero
    logic [ssrm_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    // [1:0] kind
    logic [ssrm_pkg::S_TUSER_W-1:0] s_axis_tuser  = ssrm_pkg::KIND_NOP;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [0] select_level, [1] mosi_level, [2] clock_pulse, [3] read_valid,
    // [11:4] read_byte, [12] need_data, [13] done_res, [14] rejected, [15] zero
    logic [ssrm_pkg::M_TDATA_W-1:0] m_axis_tdata;

    sensor_spi_register_master_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // sequencer mirror
    seq_phase_t  seq_phase       = SEQ_IDLE;
    int unsigned bit_pos         = 0;
    logic [7:0]  shifter         = '0;
    int unsigned bytes_remaining = 0;
    logic        rd_mode         = 1'b0;
    logic [7:0]  addr_latch      = '0;
    logic [7:0]  hold_byte       = '0;
    logic        hold_valid      = 1'b0;

    ssrm_pkg::res_t spi_results_due[$];
    int   mismatches      = 0;
    int   requests_done   = 0;
    int   idle_cycles     = 0;
    int   stall_left      = 0;
    bit   pace_requests   = 1'b1;
    bit   pace_results    = 1'b1;
    bit   hold_results_req = 1'b0;

    function automatic ssrm_pkg::res_t next_spi_result(logic [1:0] kind, logic [31:0] p);
        ssrm_pkg::res_t r;
        int unsigned    len;
        r = '0;
        case (kind)
            ssrm_pkg::KIND_START: begin
                if (seq_phase != SEQ_IDLE) begin
                    r.rejected = 1'b1;
                end else begin
                    len = 32'(p[17:9]);
                    if (len > BURST_CAP) len = BURST_CAP;
                    rd_mode         = p[0];
                    addr_latch      = p[8:1];
                    bytes_remaining = len;
                    bit_pos         = 0;
                    shifter         = '0;
                    seq_phase       = SEQ_DIR;
                end
            end
            ssrm_pkg::KIND_DATA: begin
                if (hold_valid) begin
                    r.rejected = 1'b1;
                end else begin
                    hold_byte  = p[25:18];
                    hold_valid = 1'b1;
                end
            end
            ssrm_pkg::KIND_TICK: begin
                case (seq_phase)
                    SEQ_DIR: begin
                        r.mosi_level  = !rd_mode;
                        r.clock_pulse = 1'b1;
                        shifter       = addr_latch;
                        bit_pos       = 0;
                        seq_phase     = SEQ_ADDR;
                    end
                    SEQ_ADDR: begin
                        r.mosi_level  = shifter[7];
                        r.clock_pulse = 1'b1;
                        shifter       = shifter << 1;
                        bit_pos++;
                        if (bit_pos >= 8) begin
                            bit_pos = 0;
                            if (rd_mode) begin
                                seq_phase = SEQ_DUMMY;
                            end else if (bytes_remaining == 0) begin
                                seq_phase  = SEQ_IDLE;
                                r.done_res = 1'b1;
                            end else begin
                                seq_phase = SEQ_WDATA;
                            end
                        end
                    end
                    SEQ_WDATA: begin
                        // empty holding byte at a byte boundary: no pulse
                        if (bit_pos != 0 || hold_valid) begin
                            if (bit_pos == 0) begin
                                shifter    = hold_byte;
                                hold_valid = 1'b0;
                            end
                            r.mosi_level  = shifter[7];
                            r.clock_pulse = 1'b1;
                            shifter       = shifter << 1;
                            bit_pos++;
                            if (bit_pos >= 8) begin
                                bit_pos = 0;
                                if (bytes_remaining > 0) bytes_remaining--;
                                if (bytes_remaining == 0) begin
                                    seq_phase  = SEQ_IDLE;
                                    r.done_res = 1'b1;
                                end
                            end
                        end
                    end
                    SEQ_DUMMY: begin
                        r.clock_pulse = 1'b1;
                        bit_pos       = 0;
                        shifter       = '0;
                        if (bytes_remaining == 0) begin
                            seq_phase  = SEQ_IDLE;
                            r.done_res = 1'b1;
                        end else begin
                            seq_phase = SEQ_RDATA;
                        end
                    end
                    SEQ_RDATA: begin
                        r.clock_pulse = 1'b1;
                        shifter       = {shifter[6:0], p[26]};
                        bit_pos++;
                        if (bit_pos >= 8) begin
                            r.read_valid = 1'b1;
                            r.read_byte  = shifter;
                            bit_pos      = 0;
                            shifter      = '0;
                            if (bytes_remaining > 0) bytes_remaining--;
                            if (bytes_remaining == 0) begin
                                seq_phase  = SEQ_IDLE;
                                r.done_res = 1'b1;
                            end
                        end
                    end
                    default: seq_phase = SEQ_IDLE;
                endcase
            end
            default: ;
        endcase
        r.select_level = (seq_phase != SEQ_IDLE);
        r.need_data    = (seq_phase == SEQ_WDATA) && (bit_pos == 0) && !hold_valid;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!pace_requests || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // unused fields carry random bits; the block must ignore them
    function automatic logic [31:0] noise_payload();
        return $urandom & 32'h07FF_FFFF;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [31:0] payload);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= payload;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        spi_results_due.push_back(next_spi_result(kind, payload));
        requests_done++;
    endtask

    task automatic send_start(input logic rd, input logic [7:0] addr, input logic [8:0] len);
        logic [31:0] p;
        p       = noise_payload();
        p[0]    = rd;
        p[8:1]  = addr;
        p[17:9] = len;
        send_request(ssrm_pkg::KIND_START, p);
    endtask

    task automatic send_data(input logic [7:0] b);
        logic [31:0] p;
        p        = noise_payload();
        p[25:18] = b;
        send_request(ssrm_pkg::KIND_DATA, p);
    endtask

    task automatic send_tick(input logic miso);
        logic [31:0] p;
        p     = noise_payload();
        p[26] = miso;
        send_request(ssrm_pkg::KIND_TICK, p);
    endtask

    task automatic send_noise();
        logic [1:0]  kind;
        logic [31:0] p;
        kind = 2'($urandom_range(0, 3));
        p    = noise_payload();
        if (kind == ssrm_pkg::KIND_START) p[17:9] = 9'($urandom_range(0, 6));
        send_request(kind, p);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (spi_results_due.size() != 0);
    endtask

    // well-formed burst with random content and some noise mixed in
    task automatic run_burst(input logic rd, input logic [7:0] addr, input logic [8:0] len);
        int pick;
        send_start(rd, addr, len);
        while (seq_phase != SEQ_IDLE) begin
            pick = $urandom_range(0, 99);
            if (seq_phase == SEQ_WDATA && bit_pos == 0 && !hold_valid) begin
                if (pick < 70) send_data(8'($urandom));
                else if (pick < 90) send_tick(1'($urandom));
                else send_noise();
            end else if (pick < 85) begin
                send_tick(1'($urandom));
            end else if (pick < 92) begin
                send_data(8'($urandom));
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic test_idle_requests();
        send_tick(1'b1);
        send_request(ssrm_pkg::KIND_NOP, 32'h07FF_FFFF);
        send_data(8'hFF);
        send_data(8'h00);
    endtask

    task automatic test_zero_length();
        send_start(1'b0, 8'hFF, 9'd0);
        send_request(ssrm_pkg::KIND_START, 32'h07FF_FFFF);
        repeat (9) send_tick(1'b1);
        send_start(1'b1, 8'h00, 9'd0);
        repeat (10) send_tick(1'b0);
    endtask

    // length above the cap saturates
    task automatic test_saturated_read();
        send_start(1'b1, 8'($urandom), 9'h1FF);
        while (seq_phase != SEQ_IDLE) send_tick(1'($urandom));
    endtask

    task automatic test_backpressure();
        pace_requests    = 1'b0;
        hold_results_req = 1'b1;
        run_burst(1'b0, 8'h3C, 9'd3);
        run_burst(1'b1, 8'hC3, 9'd2);
        wait_results_drained();
        pace_requests = 1'b1;
    endtask

    task automatic test_random_bursts();
        int          first;
        int          pick;
        logic [8:0]  len;
        first = requests_done;
        while (requests_done - first < RANDOM_REQUESTS) begin
            pick          = $urandom_range(0, 4);
            pace_requests = (pick != 0);
            pace_results  = (pick != 0);
            repeat ($urandom_range(0, 3)) send_noise();
            pick = $urandom_range(0, 99);
            if (pick < 60) len = 9'($urandom_range(0, 3));
            else if (pick < 90) len = 9'($urandom_range(4, 12));
            else len = 9'($urandom_range(13, 32));
            run_burst(1'($urandom), 8'($urandom), len);
            if ($urandom_range(0, 9) == 0) wait_results_drained();
        end
        pace_requests = 1'b1;
        pace_results  = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_requests();
        test_zero_length();
        test_saturated_read();
        test_backpressure();
        test_random_bursts();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (spi_results_due.size() != 0) begin
            $error("%0d results never arrived", spi_results_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side pacing
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_results_req) begin
                hold_results_req = 1'b0;
                stall_left       = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!pace_results || $urandom_range(0, 99) < 70) begin
                m_axis_tready <= 1'b1;
            end else begin
                stall_left    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                             : $urandom_range(10, 50);
                m_axis_tready <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        ssrm_pkg::res_t want;
        ssrm_pkg::res_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = ssrm_pkg::res_t'(m_axis_tdata[14:0]);
            if (spi_results_due.size() == 0) begin
                $error("result %0h with no request outstanding", m_axis_tdata);
                mismatches++;
            end else begin
                want = spi_results_due.pop_front();
                check_field("select_level", 8'(want.select_level), 8'(got.select_level));
                check_field("mosi_level",   8'(want.mosi_level),   8'(got.mosi_level));
                check_field("clock_pulse",  8'(want.clock_pulse),  8'(got.clock_pulse));
                check_field("read_valid",   8'(want.read_valid),   8'(got.read_valid));
                check_field("read_byte",    want.read_byte,        got.read_byte);
                check_field("need_data",    8'(want.need_data),    8'(got.need_data));
                check_field("done_res",     8'(want.done_res),     8'(got.done_res));
                check_field("rejected",     8'(want.rejected),     8'(got.rejected));
            end
        end
    end

    // stuck-bus guard: no request or result moving for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### sensor_spi_register_master_top.f
+incdir+rtl
rtl/ssrm_pkg.sv
rtl/ssrm_front.sv
rtl/ssrm_back.sv
rtl/sensor_spi_register_master_top.sv
tb/sv/sensor_spi_register_master_top_tb.sv
